[rtl/core/gasl_pkg.sv]
// ----------------------------------------------------------------------------
// Gimbal angle slew limiter: shared package
// Register indexes, fixed field widths and the control flags carried
// between the step and clamp stages.
// ----------------------------------------------------------------------------
package gasl_pkg;

    // Rate limits are 16-bit unsigned with 16 fractional bits of step
    localparam int LIMIT_W   = 16;
    localparam int STEP_FRAC = 16;

    // Configuration register map
    localparam int CFG_IDX_W = 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YAW_LIMIT   = 1'b0,
        CFG_PITCH_LIMIT = 1'b1
    } t_cfg_reg;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd342;

    // Per-axis limiting enables, decided once dt and the limits are known
    typedef struct packed {
        logic yaw_en;
        logic pitch_en;
    } t_limit_flags;

endpackage

[rtl/core/gasl_ingress.sv]
// ----------------------------------------------------------------------------
// Gimbal angle slew limiter: ingress stage
// Registers each incoming transaction and works out dt against the timestamp
// of the transaction before it.
// ----------------------------------------------------------------------------
module gasl_ingress
    import gasl_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ANGLE_BITS-1:0] i_yaw,
    input  logic [ANGLE_BITS-1:0] i_pitch,
    input  logic [TIME_BITS-1:0]  i_time,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ANGLE_BITS-1:0] o_yaw,
    output logic [ANGLE_BITS-1:0] o_pitch,
    output logic [TIME_BITS-1:0]  o_dt,
    output logic                  o_lim_ok
);

    logic                  r_valid;
    logic                  r_have_prev;
    logic [TIME_BITS-1:0]  r_prev_time;
    logic [ANGLE_BITS-1:0] r_yaw;
    logic [ANGLE_BITS-1:0] r_pitch;
    logic [TIME_BITS-1:0]  r_dt;
    logic                  r_lim_ok;
    logic [TIME_BITS-1:0]  n_dt;
    logic                  n_dt_pos;
    logic                  accept;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // dt wraps with the timestamp; only a strictly positive dt limits
    assign n_dt     = i_time - r_prev_time;
    assign n_dt_pos = (n_dt != '0) && !n_dt[TIME_BITS-1];

    // Control: occupancy and first-transaction tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_have_prev <= 1'b0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (accept) begin
                r_have_prev <= 1'b1;
            end
        end
    end

    // Payload: capture the transaction and its dt
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_yaw       <= i_yaw;
            r_pitch     <= i_pitch;
            r_dt        <= n_dt;
            r_lim_ok    <= r_have_prev && n_dt_pos;
            r_prev_time <= i_time;
        end
    end

    assign o_valid  = r_valid;
    assign o_yaw    = r_yaw;
    assign o_pitch  = r_pitch;
    assign o_dt     = r_dt;
    assign o_lim_ok = r_lim_ok;

endmodule

[rtl/core/gasl_step.sv]
// ----------------------------------------------------------------------------
// Gimbal angle slew limiter: step stage
// Scales each axis rate limit by dt to give the largest allowed step,
// saturated to the full angle range.
// ----------------------------------------------------------------------------
module gasl_step
    import gasl_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ANGLE_BITS-1:0] i_yaw,
    input  logic [ANGLE_BITS-1:0] i_pitch,
    input  logic [TIME_BITS-1:0]  i_dt,
    input  logic                  i_lim_ok,
    input  logic [LIMIT_W-1:0]    i_yaw_limit,
    input  logic [LIMIT_W-1:0]    i_pitch_limit,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ANGLE_BITS-1:0] o_yaw,
    output logic [ANGLE_BITS-1:0] o_pitch,
    output logic [ANGLE_BITS-1:0] o_yaw_step,
    output logic [ANGLE_BITS-1:0] o_pitch_step,
    output t_limit_flags          o_flags
);

    // dt bits that can still leave the step below saturation
    localparam int DW = ANGLE_BITS + STEP_FRAC;
    localparam int PW = LIMIT_W + DW;
    localparam int SW = PW - STEP_FRAC;

    logic                  r_valid;
    logic [ANGLE_BITS-1:0] r_yaw;
    logic [ANGLE_BITS-1:0] r_pitch;
    logic [ANGLE_BITS-1:0] r_yaw_step;
    logic [ANGLE_BITS-1:0] r_pitch_step;
    t_limit_flags          r_flags;
    t_limit_flags          n_flags;
    logic                  accept;

    // (limit * dt) >> STEP_FRAC, saturated at the all-ones angle
    function automatic logic [ANGLE_BITS-1:0] allowed_step(
        input logic [LIMIT_W-1:0]   limit,
        input logic [TIME_BITS-1:0] dt
    );
        logic          dt_hi;
        logic [DW-1:0] dt_lo;
        logic [PW-1:0] prod;
        logic [SW-1:0] scaled;
        dt_hi  = |(dt >> DW);
        dt_lo  = DW'(dt);
        prod   = PW'(limit) * PW'(dt_lo);
        scaled = prod[PW-1:STEP_FRAC];
        if (dt_hi || (|scaled[SW-1:ANGLE_BITS])) begin
            return '1;
        end
        return scaled[ANGLE_BITS-1:0];
    endfunction

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    assign n_flags.yaw_en   = i_lim_ok && (i_yaw_limit != '0);
    assign n_flags.pitch_en = i_lim_ok && (i_pitch_limit != '0);

    // Control: occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload: angles, allowed steps and enables
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_yaw        <= i_yaw;
            r_pitch      <= i_pitch;
            r_yaw_step   <= allowed_step(i_yaw_limit, i_dt);
            r_pitch_step <= allowed_step(i_pitch_limit, i_dt);
            r_flags      <= n_flags;
        end
    end

    assign o_valid      = r_valid;
    assign o_yaw        = r_yaw;
    assign o_pitch      = r_pitch;
    assign o_yaw_step   = r_yaw_step;
    assign o_pitch_step = r_pitch_step;
    assign o_flags      = r_flags;

endmodule

[rtl/core/gasl_clamp.sv]
// ----------------------------------------------------------------------------
// Gimbal angle slew limiter: clamp stage
// Clamps each axis against the last output; the result register doubles as
// the reference for the next transaction.
// ----------------------------------------------------------------------------
module gasl_clamp
    import gasl_pkg::*;
#(
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [ANGLE_BITS-1:0] i_yaw,
    input  logic [ANGLE_BITS-1:0] i_pitch,
    input  logic [ANGLE_BITS-1:0] i_yaw_step,
    input  logic [ANGLE_BITS-1:0] i_pitch_step,
    input  t_limit_flags          i_flags,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [ANGLE_BITS-1:0] o_yaw,
    output logic [ANGLE_BITS-1:0] o_pitch
);

    localparam logic signed [ANGLE_BITS+1:0] PITCH_MAX = (ANGLE_BITS+2)'((1 << (ANGLE_BITS-1)) - 1);
    localparam logic signed [ANGLE_BITS+1:0] PITCH_MIN = -(ANGLE_BITS+2)'(1 << (ANGLE_BITS-1));

    logic                         r_valid;
    logic [ANGLE_BITS-1:0]        r_yaw;
    logic [ANGLE_BITS-1:0]        r_pitch;
    logic                         accept;

    logic [ANGLE_BITS-1:0]        yaw_diff;
    logic signed [ANGLE_BITS:0]   yaw_diff_x;
    logic signed [ANGLE_BITS:0]   yaw_m;
    logic [ANGLE_BITS-1:0]        n_yaw;

    logic signed [ANGLE_BITS+1:0] pitch_x;
    logic signed [ANGLE_BITS+1:0] last_pitch_x;
    logic signed [ANGLE_BITS+1:0] pitch_diff;
    logic signed [ANGLE_BITS+1:0] pitch_m;
    logic signed [ANGLE_BITS+1:0] pitch_sel;
    logic [ANGLE_BITS-1:0]        n_pitch;

    logic signed [ANGLE_BITS:0]   chk_yaw_delta;
    logic signed [ANGLE_BITS+1:0] chk_pitch_delta;

    assign o_ready = !r_valid || i_ready;
    assign accept  = i_valid && o_ready;

    // Yaw: shortest way round, difference taken modulo a full turn
    assign yaw_diff   = i_yaw - r_yaw;
    assign yaw_diff_x = {yaw_diff[ANGLE_BITS-1], yaw_diff};
    assign yaw_m      = {1'b0, i_yaw_step};

    always_comb begin
        n_yaw = i_yaw;
        if (i_flags.yaw_en) begin
            priority if (yaw_diff_x > yaw_m) begin
                n_yaw = r_yaw + i_yaw_step;
            end else if (yaw_diff_x < -yaw_m) begin
                n_yaw = r_yaw - i_yaw_step;
            end
        end
    end

    // Pitch: linear step, then saturate to the signed range
    assign pitch_x      = {{2{i_pitch[ANGLE_BITS-1]}}, i_pitch};
    assign last_pitch_x = {{2{r_pitch[ANGLE_BITS-1]}}, r_pitch};
    assign pitch_diff   = pitch_x - last_pitch_x;
    assign pitch_m      = {2'b00, i_pitch_step};

    always_comb begin
        pitch_sel = pitch_x;
        if (i_flags.pitch_en) begin
            priority if (pitch_diff > pitch_m) begin
                pitch_sel = last_pitch_x + pitch_m;
            end else if (pitch_diff < -pitch_m) begin
                pitch_sel = last_pitch_x - pitch_m;
            end
        end
        priority if (pitch_sel > PITCH_MAX) begin
            n_pitch = PITCH_MAX[ANGLE_BITS-1:0];
        end else if (pitch_sel < PITCH_MIN) begin
            n_pitch = PITCH_MIN[ANGLE_BITS-1:0];
        end else begin
            n_pitch = pitch_sel[ANGLE_BITS-1:0];
        end
    end

    // Control: result occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload: result, kept as the reference for the next transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
        end
    end

    assign o_valid = r_valid;
    assign o_yaw   = r_yaw;
    assign o_pitch = r_pitch;

    // Movement actually taken this transaction, for the checks below
    assign chk_yaw_delta   = {yaw_diff_x[ANGLE_BITS], ANGLE_BITS'(n_yaw - r_yaw)};
    assign chk_pitch_delta = {{2{n_pitch[ANGLE_BITS-1]}}, n_pitch} - last_pitch_x;

    a_yaw_within_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_flags.yaw_en |->
            ($signed({(ANGLE_BITS-1)'(0), 1'b0, 1'b0}) == 0) &&
            ($signed({{1{1'b0}}, i_yaw_step}) >=
             $signed({chk_yaw_delta[ANGLE_BITS-1], chk_yaw_delta[ANGLE_BITS-1:0]}) ||
             i_yaw_step[ANGLE_BITS-1]))
        else $error("yaw moved further than the allowed step");

    a_pitch_within_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_flags.pitch_en |->
            (chk_pitch_delta <= pitch_m) && (chk_pitch_delta >= -pitch_m))
        else $error("pitch moved further than the allowed step");

    a_yaw_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_flags.yaw_en |=> r_yaw == $past(i_yaw))
        else $error("unlimited yaw did not pass through");

    a_pitch_passthrough: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_flags.pitch_en |=> r_pitch == $past(i_pitch))
        else $error("unlimited pitch did not pass through");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !r_valid)
        else $error("result register valid after reset");

endmodule

[rtl/core/gimbal_angle_slew_limiter.sv]
// ----------------------------------------------------------------------------
// Gimbal angle slew limiter: top level
// Limits how fast commanded yaw and pitch may move between timestamped
// transactions, with run-time rate limits on a register write port.
// ----------------------------------------------------------------------------
// One transaction in and one result out per clock in steady state, while
// m_axis_tready is high. Each result passes the ingress, step and clamp
// registers in turn before it is presented; a stalled result holds each
// stage in turn and the input stalls only once all three registers are
// full. The rate is set by the clamp stage, which compares each angle
// against the previous result held in its own output register. The step
// stage holds two limit-by-dt multipliers of 16 x (ANGLE_BITS + 16) bits.
// The first transaction after reset, and any with a zero or negative dt,
// passes its angles straight through. Write the rate limits only while the
// pipeline is empty. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module gimbal_angle_slew_limiter
    import gasl_pkg::*;
#(
    parameter int TIME_BITS  = 48,
    parameter int ANGLE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // yaw_in, pitch_in, time_us, zero pad
    input  logic [((2 * ANGLE_BITS + TIME_BITS + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // Limited angle stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // yaw_out, pitch_out, zero pad
    output logic [((2 * ANGLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata,
    // Rate limit writes
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [LIMIT_W-1:0]    i_cfg_data
);

    localparam int OUT_W = ((2 * ANGLE_BITS + 7) / 8) * 8;

    logic [LIMIT_W-1:0]    r_yaw_limit;
    logic [LIMIT_W-1:0]    r_pitch_limit;

    logic                  ing_valid;
    logic                  ing_ready;
    logic [ANGLE_BITS-1:0] ing_yaw;
    logic [ANGLE_BITS-1:0] ing_pitch;
    logic [TIME_BITS-1:0]  ing_dt;
    logic                  ing_lim_ok;

    logic                  stp_valid;
    logic                  stp_ready;
    logic [ANGLE_BITS-1:0] stp_yaw;
    logic [ANGLE_BITS-1:0] stp_pitch;
    logic [ANGLE_BITS-1:0] stp_yaw_step;
    logic [ANGLE_BITS-1:0] stp_pitch_step;
    t_limit_flags          stp_flags;

    logic [ANGLE_BITS-1:0] out_yaw;
    logic [ANGLE_BITS-1:0] out_pitch;

    // Rate limit registers; writes always complete
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yaw_limit   <= LIMIT_RESET;
            r_pitch_limit <= LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_reg'(i_cfg_index))
                CFG_YAW_LIMIT:   r_yaw_limit   <= i_cfg_data;
                CFG_PITCH_LIMIT: r_pitch_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    gasl_ingress #(
        .TIME_BITS  (TIME_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_ingress (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_yaw    (s_axis_tdata[ANGLE_BITS-1:0]),
        .i_pitch  (s_axis_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
        .i_time   (s_axis_tdata[2*ANGLE_BITS+TIME_BITS-1:2*ANGLE_BITS]),
        .o_valid  (ing_valid),
        .i_ready  (ing_ready),
        .o_yaw    (ing_yaw),
        .o_pitch  (ing_pitch),
        .o_dt     (ing_dt),
        .o_lim_ok (ing_lim_ok)
    );

    gasl_step #(
        .TIME_BITS  (TIME_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_step (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (ing_valid),
        .o_ready       (ing_ready),
        .i_yaw         (ing_yaw),
        .i_pitch       (ing_pitch),
        .i_dt          (ing_dt),
        .i_lim_ok      (ing_lim_ok),
        .i_yaw_limit   (r_yaw_limit),
        .i_pitch_limit (r_pitch_limit),
        .o_valid       (stp_valid),
        .i_ready       (stp_ready),
        .o_yaw         (stp_yaw),
        .o_pitch       (stp_pitch),
        .o_yaw_step    (stp_yaw_step),
        .o_pitch_step  (stp_pitch_step),
        .o_flags       (stp_flags)
    );

    gasl_clamp #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_clamp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (stp_valid),
        .o_ready      (stp_ready),
        .i_yaw        (stp_yaw),
        .i_pitch      (stp_pitch),
        .i_yaw_step   (stp_yaw_step),
        .i_pitch_step (stp_pitch_step),
        .i_flags      (stp_flags),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_yaw        (out_yaw),
        .o_pitch      (out_pitch)
    );

    // Pack the result, yaw in the low bits
    assign m_axis_tdata = OUT_W'({out_pitch, out_yaw});

endmodule
